// File: rtl/segment_rectangle_intersect_assert.svh
// Assertion macros for the segment/rectangle contact block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SEGMENT_RECTANGLE_INTERSECT_ASSERT_SVH
`define SEGMENT_RECTANGLE_INTERSECT_ASSERT_SVH

// Same-cycle implication.
`define SRI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SRI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/sri_pkg.sv
`default_nettype none

package sri_pkg;

    // Coordinate width and the widths that follow from it
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int NUM_FIELDS = 8;
    localparam int IN_W       = NUM_FIELDS * COORD_BITS;
    localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;
    localparam int NUM_EDGES  = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // First stage: sorted rectangle bounds, segment extent, segment direction
    typedef struct packed {
        point_t a;
        point_t b;
        coord_t x0;
        coord_t x1;
        coord_t y0;
        coord_t y1;
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        diff_t  dab_x;
        diff_t  dab_y;
    } prep_t;

    // Second stage: cross product halves per corner, endpoint and per-edge flags
    typedef struct packed {
        prod_t [NUM_EDGES-1:0]  lhs;
        prod_t [NUM_EDGES-1:0]  rhs;
        logic                   end_in;
        logic [NUM_EDGES-1:0]   side_rej;
        logic [NUM_EDGES-1:0]   box_ok;
    } orient_t;

    function automatic coord_t cmin(coord_t p, coord_t q);
        return (p < q) ? p : q;
    endfunction

    function automatic coord_t cmax(coord_t p, coord_t q);
        return (p > q) ? p : q;
    endfunction

    function automatic logic cle(coord_t p, coord_t q);
        return p <= q;
    endfunction

    function automatic logic clt(coord_t p, coord_t q);
        return p < q;
    endfunction

    function automatic diff_t coord_diff(coord_t p, coord_t q);
        return diff_t'(p) - diff_t'(q);
    endfunction

    function automatic prod_t diff_mul(diff_t p, diff_t q);
        return prod_t'(p) * prod_t'(q);
    endfunction

    // Sign of l - r as {positive, negative}
    function automatic logic [1:0] cross_sign(prod_t l, prod_t r);
        cross_t c;
        c = cross_t'(l) - cross_t'(r);
        return {(!c[CROSS_W-1]) && (c != '0), c[CROSS_W-1]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/sri_prep.sv
`default_nettype none

module sri_prep
    import sri_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [S_TDATA_W-1:0] in_data,
    output logic                      valid_reg,
    output prep_t                     data_reg
);

    coord_t f [NUM_FIELDS];
    prep_t  data_next;

    // Unpack coordinates from the stream word
    always_comb
    begin
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            f[k] = coord_t'(in_data[k*COORD_BITS +: COORD_BITS]);
        end
    end

    // Sort corners, segment extent, direction vector
    always_comb
    begin
        data_next.a.x  = f[0];
        data_next.a.y  = f[1];
        data_next.b.x  = f[2];
        data_next.b.y  = f[3];
        data_next.x0   = cmin(f[4], f[6]);
        data_next.x1   = cmax(f[4], f[6]);
        data_next.y0   = cmin(f[5], f[7]);
        data_next.y1   = cmax(f[5], f[7]);
        data_next.min_x = cmin(f[0], f[2]);
        data_next.max_x = cmax(f[0], f[2]);
        data_next.min_y = cmin(f[1], f[3]);
        data_next.max_y = cmax(f[1], f[3]);
        data_next.dab_x = coord_diff(f[2], f[0]);
        data_next.dab_y = coord_diff(f[3], f[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sri_orient.sv
`default_nettype none

module sri_orient
    import sri_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire prep_t in_data,
    output logic       valid_reg,
    output orient_t    data_reg
);

    point_t  corner [NUM_EDGES];
    orient_t data_next;
    logic    in_a;
    logic    in_b;
    logic    x_nz;
    logic    y_nz;

    // Rectangle corners counterclockwise from (x0, y0)
    always_comb
    begin
        corner[0].x = in_data.x0;
        corner[0].y = in_data.y0;
        corner[1].x = in_data.x1;
        corner[1].y = in_data.y0;
        corner[2].x = in_data.x1;
        corner[2].y = in_data.y1;
        corner[3].x = in_data.x0;
        corner[3].y = in_data.y1;
    end

    always_comb
    begin
        // Cross product halves of each corner against the segment line
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            data_next.lhs[k] = diff_mul(in_data.dab_x,
                                        coord_diff(corner[k].y, in_data.a.y));
            data_next.rhs[k] = diff_mul(in_data.dab_y,
                                        coord_diff(corner[k].x, in_data.a.x));
        end

        // Endpoint containment
        in_a = cle(in_data.x0, in_data.a.x) && cle(in_data.a.x, in_data.x1) &&
               cle(in_data.y0, in_data.a.y) && cle(in_data.a.y, in_data.y1);
        in_b = cle(in_data.x0, in_data.b.x) && cle(in_data.b.x, in_data.x1) &&
               cle(in_data.y0, in_data.b.y) && cle(in_data.b.y, in_data.y1);
        data_next.end_in = in_a || in_b;

        // Edge-side test: both endpoints strictly on one side of a non-degenerate edge
        x_nz = (in_data.x1 != in_data.x0);
        y_nz = (in_data.y1 != in_data.y0);
        data_next.side_rej[0] = x_nz &&
            ((clt(in_data.y0, in_data.a.y) && clt(in_data.y0, in_data.b.y)) ||
             (clt(in_data.a.y, in_data.y0) && clt(in_data.b.y, in_data.y0)));
        data_next.side_rej[1] = y_nz &&
            ((clt(in_data.x1, in_data.a.x) && clt(in_data.x1, in_data.b.x)) ||
             (clt(in_data.a.x, in_data.x1) && clt(in_data.b.x, in_data.x1)));
        data_next.side_rej[2] = x_nz &&
            ((clt(in_data.y1, in_data.a.y) && clt(in_data.y1, in_data.b.y)) ||
             (clt(in_data.a.y, in_data.y1) && clt(in_data.b.y, in_data.y1)));
        data_next.side_rej[3] = y_nz &&
            ((clt(in_data.x0, in_data.a.x) && clt(in_data.x0, in_data.b.x)) ||
             (clt(in_data.a.x, in_data.x0) && clt(in_data.b.x, in_data.x0)));

        // Bounding box overlap of the segment with each edge
        data_next.box_ok[0] = cle(in_data.x0, in_data.max_x) &&
                              cle(in_data.min_x, in_data.x1) &&
                              cle(in_data.y0, in_data.max_y) &&
                              cle(in_data.min_y, in_data.y0);
        data_next.box_ok[1] = cle(in_data.x1, in_data.max_x) &&
                              cle(in_data.min_x, in_data.x1) &&
                              cle(in_data.y0, in_data.max_y) &&
                              cle(in_data.min_y, in_data.y1);
        data_next.box_ok[2] = cle(in_data.x0, in_data.max_x) &&
                              cle(in_data.min_x, in_data.x1) &&
                              cle(in_data.y1, in_data.max_y) &&
                              cle(in_data.min_y, in_data.y1);
        data_next.box_ok[3] = cle(in_data.x0, in_data.max_x) &&
                              cle(in_data.min_x, in_data.x0) &&
                              cle(in_data.y0, in_data.max_y) &&
                              cle(in_data.min_y, in_data.y1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sri_decide.sv
`default_nettype none

module sri_decide
    import sri_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire orient_t in_data,
    output logic         valid_reg,
    output logic         hit_reg
);

    logic [1:0]           osign [NUM_EDGES];
    logic [NUM_EDGES-1:0] line_rej;
    logic [NUM_EDGES-1:0] edge_hit;
    logic                 hit_next;

    // Orientation of each corner relative to the segment line
    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            osign[k] = cross_sign(in_data.lhs[k], in_data.rhs[k]);
        end
    end

    // Edge k runs from corner k to corner k+1; reject when both lie strictly
    // on one side of the segment line
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            line_rej[e] = (osign[e][1] && osign[(e + 1) % NUM_EDGES][1]) ||
                          (osign[e][0] && osign[(e + 1) % NUM_EDGES][0]);
        end
        edge_hit = ~line_rej & ~in_data.side_rej & in_data.box_ok;
        hit_next = in_data.end_in || (|edge_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/segment_rectangle_intersect.sv
// Segment versus closed axis-aligned rectangle contact test.
// Input stream s_*: one query per item, eight signed coordinates (segment
// start, segment end, two opposite rectangle corners in any order).
// Output stream m_*: one item per query, bit 0 of m_tdata is 1 when the
// segment shares at least one point with the solid rectangle.
// Pipeline: three register stages (corner sort, cross products, sign
// decision); an accepted query passes through them in order, and m_tvalid
// rises once it has left the sign decision stage.
// Throughput: one item per cycle while m_tready stays high; every stage is a
// register with its own valid bit and the multipliers sit inside the cross product stage.
// Backpressure: a stage advances when it is empty or the stage after it
// advances, so bubbles are squeezed out and s_tready stays high as long as
// any stage has room. A stalled result is held in m_tdata unchanged.
// Reset: rst_n clears all valid bits; the pipeline comes up empty and ready.
// Results leave in the order queries were accepted.
`default_nettype none
`include "segment_rectangle_intersect_assert.svh"

module segment_rectangle_intersect
    import sri_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // s_tdata fields, low bit up: seg_start_x, seg_start_y, seg_end_x,
    // seg_end_y, corner_a_x, corner_a_y, corner_b_x, corner_b_y
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // m_tdata fields, low bit up: hit, then zero padding
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);

    logic    prep_valid;
    prep_t   prep_data;
    logic    orient_valid;
    orient_t orient_data;
    logic    out_valid;
    logic    hit;
    logic    en_prep;
    logic    en_orient;
    logic    en_out;

    // Stage advance chain from the output back to the input
    always_comb
    begin
        en_out    = !out_valid || m_tready;
        en_orient = !orient_valid || en_out;
        en_prep   = !prep_valid || en_orient;
        s_tready  = en_prep;
    end

    sri_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_prep),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .valid_reg (prep_valid),
        .data_reg  (prep_data)
    );

    sri_orient u_orient (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_orient),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .valid_reg (orient_valid),
        .data_reg  (orient_data)
    );

    sri_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_out),
        .in_valid  (orient_valid),
        .in_data   (orient_data),
        .valid_reg (out_valid),
        .hit_reg   (hit)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, hit};

    // An empty output register never blocks the input
    `SRI_ASSERT_IMP(a_ready_when_out_empty, !m_tvalid, s_tready)

    // A finished item moving into the output register shows up as valid
    `SRI_ASSERT_NXT(a_result_lands, orient_valid && en_out, m_tvalid)

    // An endpoint inside the rectangle always reports a hit
    `SRI_ASSERT_NXT(a_inside_hits, orient_valid && en_out && orient_data.end_in, m_tdata[0])

endmodule

`default_nettype wire
